@@ rtl/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg: shared types for the strip to triangle list assembler
// index and count widths, outcome codes, input and result item structs
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int INDEX_WIDTH = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int SEEN_WIDTH  = 2;

    typedef enum logic [1:0] {
        OUTCOME_NONE    = 2'd0,
        OUTCOME_KEPT    = 2'd1,
        OUTCOME_DROPPED = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] vertex_index;
        logic                   strip_start;
        logic                   mesh_start;
    } t_vertex_in;

    typedef struct packed {
        t_outcome               outcome;
        logic [INDEX_WIDTH-1:0] corner_first;
        logic [INDEX_WIDTH-1:0] corner_second;
        logic [INDEX_WIDTH-1:0] corner_third;
        logic [COUNT_WIDTH-1:0] degenerate_total;
    } t_tri_out;

endpackage

@@ rtl/stl_in_stage.sv @@
// ----------------------------------------------------------------------------
// stl_in_stage: input register
// holds one incoming vertex item until the assembly stage takes it
// ----------------------------------------------------------------------------
module stl_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  stl_pkg::t_vertex_in i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output stl_pkg::t_vertex_in o_item
);
    import stl_pkg::*;

    logic       r_valid;
    t_vertex_in r_item;

    // free, or emptying this cycle
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/stl_assemble.sv @@
// ----------------------------------------------------------------------------
// stl_assemble: strip state, triangle test and result register
// forms at most one candidate triangle per index and registers the result item
// ----------------------------------------------------------------------------
module stl_assemble (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  stl_pkg::t_vertex_in i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output stl_pkg::t_tri_out   o_item
);
    import stl_pkg::*;

    logic [INDEX_WIDTH-1:0] r_older;
    logic [INDEX_WIDTH-1:0] r_newer;
    logic [SEEN_WIDTH-1:0]  r_seen;
    logic                   r_odd;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_out_valid;
    t_tri_out               r_result;

    logic [SEEN_WIDTH-1:0]  seen_eff;
    logic                   odd_eff;
    logic [COUNT_WIDTH-1:0] count_eff;
    logic                   candidate;
    logic                   degenerate;
    logic                   take;

    logic [SEEN_WIDTH-1:0]  n_seen;
    logic                   n_odd;
    logic [COUNT_WIDTH-1:0] n_count;
    t_tri_out               n_result;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        // flags act before the index is handled
        seen_eff   = i_item.strip_start ? '0 : r_seen;
        odd_eff    = i_item.strip_start ? 1'b0 : r_odd;
        count_eff  = i_item.mesh_start ? '0 : r_count;
        candidate  = (seen_eff >= SEEN_WIDTH'(2));
        degenerate = (r_older == r_newer) || (r_newer == i_item.vertex_index)
                     || (r_older == i_item.vertex_index);

        n_seen  = candidate ? seen_eff : seen_eff + SEEN_WIDTH'(1);
        n_odd   = candidate ? !odd_eff : odd_eff;
        n_count = count_eff;
        if (candidate && degenerate && (count_eff != '1)) begin
            n_count = count_eff + COUNT_WIDTH'(1);
        end

        n_result.outcome          = OUTCOME_NONE;
        n_result.corner_first     = '0;
        n_result.corner_second    = '0;
        n_result.corner_third     = '0;
        n_result.degenerate_total = n_count;
        if (candidate) begin
            if (degenerate) begin
                n_result.outcome = OUTCOME_DROPPED;
            end else begin
                n_result.outcome       = OUTCOME_KEPT;
                n_result.corner_first  = r_older;
                // odd triangles swap the last two corners for winding
                n_result.corner_second = odd_eff ? i_item.vertex_index : r_newer;
                n_result.corner_third  = odd_eff ? r_newer : i_item.vertex_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= '0;
            r_newer     <= '0;
            r_seen      <= '0;
            r_odd       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_older     <= r_newer;
            r_newer     <= i_item.vertex_index;
            r_seen      <= n_seen;
            r_odd       <= n_odd;
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_result;

endmodule

@@ rtl/strip_to_triangle_list.sv @@
// ----------------------------------------------------------------------------
// strip_to_triangle_list: triangle strip to triangle list assembler
// turns a stream of strip vertex indices into kept or dropped triangles
// ----------------------------------------------------------------------------
// usage
//   input channel carries one vertex index per item with strip_start and
//   mesh_start flags; output channel returns exactly one result item per
//   input item: no triangle yet, a kept triangle with its three corners,
//   or a dropped degenerate triangle, always with the running drop count
//   the input register loads at the accepting edge, and the assembly logic
//   feeds the result register, which holds the result item until it is taken
//   throughput is one item per cycle while the receiver keeps up; the strip
//   state (two previous indices, seen count, parity, drop count) updates in
//   the single assembly stage, so back-to-back items never wait on each other
//   when the receiver stalls, the result register holds its item and the
//   input register still takes one more item, after which o_in_ready drops
//   reset (synchronous, active low) empties both registers and clears the
//   strip state, so a stream without a leading strip flag starts a strip
// ----------------------------------------------------------------------------
module strip_to_triangle_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stl_pkg::t_vertex_in i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stl_pkg::t_tri_out   o_out_item
);
    import stl_pkg::*;

    // input register to assembly stage
    logic       stage_valid;
    logic       stage_ready;
    t_vertex_in stage_item;

    // input register: decouples the source from the assembly stage
    stl_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (stage_valid),
        .i_ready (stage_ready),
        .o_item  (stage_item)
    );

    // strip state, degenerate test, winding swap and result register
    stl_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .o_ready (stage_ready),
        .i_item  (stage_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

@@ rtl/stl_checker.sv @@
// ----------------------------------------------------------------------------
// stl_checker: port-level checks for the strip assembler
// watches the top level ports and flags result items that break the rules
// ----------------------------------------------------------------------------
module stl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input stl_pkg::t_tri_out o_out_item
);
    import stl_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    // a kept triangle never has two equal corners
    a_kept_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.outcome == OUTCOME_KEPT |->
            o_out_item.corner_first != o_out_item.corner_second &&
            o_out_item.corner_second != o_out_item.corner_third &&
            o_out_item.corner_first != o_out_item.corner_third)
        else $error("kept triangle with equal corners");

    // no kept triangle means zero corners
    a_empty_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.outcome != OUTCOME_KEPT |->
            o_out_item.corner_first == '0 && o_out_item.corner_second == '0 &&
            o_out_item.corner_third == '0)
        else $error("corners set without a kept triangle");

    // an empty pipeline always takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind strip_to_triangle_list stl_checker u_stl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

@@ tb/tb_strip_to_triangle_list.sv @@
// ----------------------------------------------------------------------------
// tb_strip_to_triangle_list: self-checking bench for the strip assembler
// drives strips of vertex indices through the valid/ready input channel,
// predicts every result item from its own copy of the strip state and
// compares it field by field against what the block returns
// ----------------------------------------------------------------------------
module tb_strip_to_triangle_list;
    import stl_pkg::*;

    // predicts triangles from accepted vertex items and checks returned results
    class triangle_scoreboard;
        logic [INDEX_WIDTH-1:0] prev_older;
        logic [INDEX_WIDTH-1:0] prev_newer;
        int unsigned            strip_seen;
        bit                     winding_odd;
        logic [COUNT_WIDTH-1:0] drop_count;
        t_tri_out               triangle_q[$];
        int unsigned            error_count;
        int unsigned            vertices_taken;
        int unsigned            kept_total;
        int unsigned            dropped_total;
        int unsigned            none_total;

        function new();
            prev_older     = '0;
            prev_newer     = '0;
            strip_seen     = 0;
            winding_odd    = 1'b0;
            drop_count     = '0;
            error_count    = 0;
            vertices_taken = 0;
            kept_total     = 0;
            dropped_total  = 0;
            none_total     = 0;
        endfunction

        function int pending();
            return triangle_q.size();
        endfunction

        // one accepted vertex yields exactly one expected result
        function void note_vertex(t_vertex_in v);
            t_tri_out               tri_exp;
            logic [INDEX_WIDTH-1:0] a;
            logic [INDEX_WIDTH-1:0] b;
            logic [INDEX_WIDTH-1:0] c;
            tri_exp = '0;
            tri_exp.outcome = OUTCOME_NONE;
            vertices_taken++;
            if (v.mesh_start) begin
                drop_count = '0;
            end
            if (v.strip_start) begin
                strip_seen  = 0;
                winding_odd = 1'b0;
            end
            if (strip_seen >= 2) begin
                a = prev_older;
                b = prev_newer;
                c = v.vertex_index;
                if (a == b || b == c || a == c) begin
                    tri_exp.outcome = OUTCOME_DROPPED;
                    if (drop_count != '1) begin
                        drop_count = drop_count + COUNT_WIDTH'(1);
                    end
                    dropped_total++;
                end else begin
                    tri_exp.outcome       = OUTCOME_KEPT;
                    tri_exp.corner_first  = a;
                    tri_exp.corner_second = winding_odd ? c : b;
                    tri_exp.corner_third  = winding_odd ? b : c;
                    kept_total++;
                end
                winding_odd = ~winding_odd;
            end else begin
                strip_seen++;
                none_total++;
            end
            prev_older = prev_newer;
            prev_newer = v.vertex_index;
            tri_exp.degenerate_total = drop_count;
            triangle_q.insert(triangle_q.size(), tri_exp);
        endfunction

        function void check_triangle(t_tri_out got);
            t_tri_out want;
            if (triangle_q.size() == 0) begin
                $error("result item with no vertex outstanding: outcome %0d",
                       got.outcome);
                error_count++;
                return;
            end
            want = triangle_q.pop_front();
            if (got.outcome !== want.outcome) begin
                $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
                error_count++;
            end
            if (got.corner_first !== want.corner_first) begin
                $error("corner_first: expected %h, actual %h",
                       want.corner_first, got.corner_first);
                error_count++;
            end
            if (got.corner_second !== want.corner_second) begin
                $error("corner_second: expected %h, actual %h",
                       want.corner_second, got.corner_second);
                error_count++;
            end
            if (got.corner_third !== want.corner_third) begin
                $error("corner_third: expected %h, actual %h",
                       want.corner_third, got.corner_third);
                error_count++;
            end
            if (got.degenerate_total !== want.degenerate_total) begin
                $error("degenerate_total: expected %0d, actual %0d",
                       want.degenerate_total, got.degenerate_total);
                error_count++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       in_valid   = 1'b0;
    logic       out_ready  = 1'b0;
    t_vertex_in in_item    = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_tri_out   o_out_item;

    triangle_scoreboard sb = new();

    // vertex items queued for the sender, directed ones first
    t_vertex_in  vertex_stream[$];
    // flipped by the sender to ask the receiver for a long hold-off
    bit          hold_toggle = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned holds_done  = 0;
    int unsigned drains_done = 0;

    strip_to_triangle_list uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // watchdog: a stuck handshake ends the run here
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, sb.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // both channels sampled at the edge; all drives are nonblocking, so these
    // reads see the values that held just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // note the input first so a same-edge result never beats its item
            if (in_valid && o_in_ready) begin
                sb.note_vertex(in_item);
            end
            if (o_out_valid && out_ready) begin
                sb.check_triangle(o_out_item);
            end
        end
    end

    // receiver: ready pattern changes in spans, with long hold-offs on request
    initial begin : receiver
        bit          hold_seen;
        int unsigned hold_left;
        int unsigned span_left;
        int unsigned mode;
        hold_seen = 1'b0;
        hold_left = 0;
        span_left = 0;
        mode      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (span_left == 0) begin
                mode      = $urandom_range(0, 3);
                span_left = $urandom_range(20, 200);
            end
            span_left--;
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= span_left[0];
                endcase
            end
        end
    end

    function automatic t_vertex_in make_vertex(logic [INDEX_WIDTH-1:0] idx,
                                               logic strip, logic mesh);
        t_vertex_in v;
        v.vertex_index = idx;
        v.strip_start  = strip;
        v.mesh_start   = mesh;
        return v;
    endfunction

    // appends one vertex item to the sender's list
    task automatic queue_vertex(logic [INDEX_WIDTH-1:0] idx, logic strip, logic mesh);
        vertex_stream.insert(vertex_stream.size(), make_vertex(idx, strip, mesh));
    endtask

    // index pools: tiny ranges make repeated corners, i.e. degenerate triangles
    function automatic logic [INDEX_WIDTH-1:0] pick_index(int unsigned pool);
        logic [INDEX_WIDTH-1:0] idx;
        case (pool)
            0: idx = INDEX_WIDTH'($urandom_range(0, 4));
            1: idx = $urandom_range(0, 1) ? INDEX_WIDTH'($urandom_range(0, 3))
                     : {INDEX_WIDTH{1'b1}} - INDEX_WIDTH'($urandom_range(0, 3));
            2: idx = INDEX_WIDTH'($urandom_range(0, 31));
            default: idx = INDEX_WIDTH'($urandom);
        endcase
        return idx;
    endfunction

    task automatic build_directed();
        // no leading strip flag: the first three still make a strip
        queue_vertex(16'd5, 1'b0, 1'b0);
        queue_vertex(16'd7, 1'b0, 1'b0);
        queue_vertex(16'd9, 1'b0, 1'b0);
        queue_vertex(16'd11, 1'b0, 1'b0);   // odd, swapped
        // both flags at once, then index extremes
        queue_vertex(16'h0000, 1'b1, 1'b1);
        queue_vertex(16'hFFFF, 1'b0, 1'b0);
        queue_vertex(16'h8000, 1'b0, 1'b0);
        queue_vertex(16'h0000, 1'b0, 1'b0);
        // repeated corners in each position pair
        queue_vertex(16'h0000, 1'b0, 1'b0); // newer == new
        queue_vertex(16'h5555, 1'b0, 1'b0); // older == newer
        queue_vertex(16'h0000, 1'b0, 1'b0); // older == new
        // mesh flag alone clears the count mid strip
        queue_vertex(16'hAAAA, 1'b0, 1'b1);
        // strip restarted before it reached a triangle
        queue_vertex(16'd3, 1'b1, 1'b0);
        queue_vertex(16'd4, 1'b1, 1'b0);
        queue_vertex(16'd6, 1'b0, 1'b0);
        queue_vertex(16'd3, 1'b0, 1'b0);
        queue_vertex(16'd4, 1'b0, 1'b0);
        // all-equal strip, then a drop right after a mesh clear
        queue_vertex(16'hFFFF, 1'b1, 1'b0);
        queue_vertex(16'hFFFF, 1'b0, 1'b0);
        queue_vertex(16'hFFFF, 1'b0, 1'b0);
        queue_vertex(16'd1, 1'b0, 1'b1);
        queue_vertex(16'd2, 1'b1, 1'b1);
    endtask

    // mostly well-formed strips with random content, some loose noise
    task automatic build_random(int unsigned goal);
        int unsigned base;
        int unsigned strip_len;
        int unsigned pool;
        int unsigned k;
        base = vertex_stream.size();
        while (vertex_stream.size() - base < goal) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    queue_vertex(INDEX_WIDTH'($urandom), 1'($urandom_range(0, 1)),
                                 ($urandom_range(0, 3) == 0));
                end
            end else begin
                strip_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 10);
                pool = $urandom_range(0, 3);
                for (k = 0; k < strip_len; k++) begin
                    queue_vertex(
                        pick_index(pool),
                        (k == 0),
                        (k == 0) ? ($urandom_range(0, 7) == 0)
                                 : ($urandom_range(0, 39) == 0));
                end
            end
        end
    endtask

    // holds valid until the item is taken; returns at the accepting edge
    task automatic send_vertex(t_vertex_in v);
        in_valid <= 1'b1;
        in_item  <= v;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (sb.pending() != 0);
    endtask

    initial begin : stimulus
        int unsigned hold_points[3];
        int unsigned drain_points[2];
        int unsigned burst_left;
        int unsigned gap;
        int unsigned n;
        int unsigned j;

        build_directed();
        build_random(RANDOM_ITEMS);
        hold_points[0]  = 5;
        hold_points[1]  = vertex_stream.size() / 4;
        hold_points[2]  = (vertex_stream.size() * 3) / 4;
        drain_points[0] = 21;
        drain_points[1] = vertex_stream.size() / 2;

        // synchronous reset held, then released
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = 0;
        for (n = 0; n < vertex_stream.size(); n++) begin
            // long receiver hold-off while items keep coming: fills the pipe
            for (j = 0; j < 3; j++) begin
                if (n == hold_points[j]) begin
                    hold_toggle = ~hold_toggle;
                    holds_done++;
                    burst_left = 200;
                end
            end
            send_vertex(vertex_stream[n]);
            // sender pause until every result is back
            if (n == drain_points[0] || n == drain_points[1]) begin
                in_valid <= 1'b0;
                wait_drained();
                drains_done++;
            end else if (burst_left > 0) begin
                burst_left--;
            end else begin
                // end of burst: random gap, often none at all
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                         : $urandom_range(1, 16);
            end
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.error_count++;
        end
        $display("covered %0d vertex items: %0d triangles kept, %0d dropped, %0d without one",
                 sb.vertices_taken, sb.kept_total, sb.dropped_total, sb.none_total);
        $display("with %0d receiver hold-offs, %0d full drains, %0d cycles, %0d mismatches",
                 holds_done, drains_done, cycle_count, sb.error_count);
        if (sb.error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
